// File: hdl/vpm_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the virtual page map allocator. No dependencies.
package vpm_pkg;

  localparam int VIRT_PAGES = 8192;
  localparam int PHYS_PAGES = 4096;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 26;
  localparam int BASE_W      = 12;
  localparam int COUNT_W     = 13;
  localparam int PA_W        = 24;
  localparam int CFG_DATA_W  = 13;

  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int VPN_W       = $clog2(VIRT_PAGES);
  localparam int PPN_W       = $clog2(PHYS_PAGES);
  localparam int ENTRY_W     = PPN_W + 1;
  localparam int CUR_W       = (BASE_W > PPN_W) ? BASE_W : PPN_W;
  localparam int END_W       = PPN_W + 1;
  localparam int SUM_W       = ((BASE_W > COUNT_W) ? BASE_W : COUNT_W) + 1;
  localparam int PAGES_W     = BYTES_W - PAGE_SHIFT + 1;
  localparam int NEED_W      = ((END_W > PAGES_W) ? END_W : PAGES_W) + 1;
  localparam int CLR_N       = (VIRT_PAGES > PHYS_PAGES) ? VIRT_PAGES : PHYS_PAGES;
  localparam int CLR_W       = $clog2(CLR_N);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DIRTY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_BASE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic prep;
    logic start_alloc;
    logic probe;
    logic take;
    logic lk_finish;
    logic res_set;
    logic res_val;
    logic out_load;
  } vpm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic size_fail;
    logic zero_pages;
    logic exhausted;
    logic used_hit;
    logic last_page;
    logic slot_free;
  } vpm_status_t;

endpackage

// File: hdl/vpm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module vpm_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vpm_ctrl.sv
// Sequencer for clearing, allocation search, lookup and result hand-off.
// Depends on vpm_pkg.
module vpm_ctrl import vpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  in_cmd_i,
  output logic        in_ready_o,
  input  vpm_status_t status_i,
  output vpm_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_PREP    = 9'b000000100,
    S_CHECK   = 9'b000001000,
    S_PROBE   = 9'b000010000,
    S_TEST    = 9'b000100000,
    S_LK_READ = 9'b001000000,
    S_LK_DATA = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          unique case (cmd_e'(in_cmd_i)) inside
            CMD_ALLOC: state_d = S_PREP;
            CMD_LOOKUP, CMD_DIRTY: state_d = S_LK_READ;
            default: begin
              cmd_o.res_set = 1'b1;
              state_d       = S_RESP;
            end
          endcase
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.size_fail) begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
        end else if (status_i.zero_pages) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.start_alloc = 1'b1;
          state_d           = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status_i.exhausted) begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = S_TEST;
        end
      end
      S_TEST: begin
        if (!status_i.used_hit) begin
          cmd_o.take = 1'b1;
          if (status_i.last_page) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_val = 1'b1;
            state_d       = S_RESP;
          end else begin
            state_d = S_PROBE;
          end
        end else begin
          state_d = S_PROBE;
        end
      end
      S_LK_READ: state_d = S_LK_DATA;
      S_LK_DATA: begin
        cmd_o.lk_finish = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (status_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/vpm_datapath.sv
// Configuration registers, page tables, search registers and result register.
// Depends on vpm_pkg and vpm_ram.
module vpm_datapath import vpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            in_cmd_i,
  input  logic [ADDR_W-1:0]     in_addr_i,
  input  logic [BYTES_W-1:0]    in_bytes_i,
  input  vpm_cmd_t              cmd_i,
  output vpm_status_t           status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_ok_o,
  output logic [PA_W-1:0]       out_pa_o,
  output logic                  out_mapped_o,
  output logic                  out_dirty_o,
  output logic                  out_err_o
);

  localparam int PA_FULL_W = PPN_W + PAGE_SHIFT;

  logic [BASE_W-1:0]  base_q;
  logic [COUNT_W-1:0] count_q;
  logic [CLR_W-1:0]   clr_q;
  logic [CUR_W-1:0]   ncp_q, ncp_d;
  logic [END_W-1:0]   alloc_q;
  logic [END_W-1:0]   end_q, avail_q, n_q;
  logic [PAGES_W-1:0] pages_q, rem_q;
  logic [VPN_W-1:0]   vpage_q;
  logic [BYTES_W-1:0] bytes_q;
  cmd_e               cmd_q;

  logic               res_ok_q, res_mapped_q, res_dirty_q, res_err_q;
  logic [PA_W-1:0]    res_pa_q;
  logic               out_valid_q, out_ok_q, out_mapped_q, out_dirty_q, out_err_q;
  logic [PA_W-1:0]    out_pa_q;

  logic [SUM_W-1:0]   sum;
  logic [END_W-1:0]   end_c, avail_c;
  logic [PAGES_W-1:0] pages_c;
  logic [BYTES_W:0]   bytes_up;
  logic [NEED_W-1:0]  need;
  logic [CUR_W:0]     cur_inc;
  logic [CUR_W-1:0]   cur_nxt;

  logic               used_we, used_wdata, used_rdata;
  logic [PPN_W-1:0]   used_addr;
  logic               v2p_we;
  logic [VPN_W-1:0]   v2p_addr;
  logic [ENTRY_W-1:0] v2p_wdata, v2p_rdata, entry;
  logic [PPN_W-1:0]   page;
  logic               mapped;
  logic [PA_FULL_W-1:0] pa_full;

  assign cfg_ready_o = 1'b1;

  assign sum      = SUM_W'(base_q) + SUM_W'(count_q);
  assign end_c    = (sum > SUM_W'(PHYS_PAGES)) ? END_W'(PHYS_PAGES) : END_W'(sum);
  assign avail_c  = ({1'b0, end_c} > (END_W + 1)'(base_q))
                    ? END_W'(end_c - END_W'(base_q)) : '0;
  assign bytes_up = (BYTES_W + 1)'(bytes_q) + (BYTES_W + 1)'(PAGE_BYTES - 1);
  assign pages_c  = PAGES_W'(bytes_up >> PAGE_SHIFT);
  assign need     = NEED_W'(alloc_q) + NEED_W'(pages_q);

  assign cur_inc  = (CUR_W + 1)'(ncp_q) + (CUR_W + 1)'(1);
  assign cur_nxt  = (cur_inc >= (CUR_W + 1)'(end_q)) ? CUR_W'(base_q) : cur_inc[CUR_W-1:0];

  assign status_o.clr_done   = (clr_q == CLR_W'(CLR_N - 1));
  assign status_o.size_fail  = (need > NEED_W'(avail_q));
  assign status_o.zero_pages = (pages_q == '0);
  assign status_o.exhausted  = (n_q == avail_q);
  assign status_o.used_hit   = used_rdata;
  assign status_o.last_page  = (rem_q == PAGES_W'(1));
  assign status_o.slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (cmd_i.clr_step) begin
      used_addr = clr_q[PPN_W-1:0];
    end else if (cmd_i.probe) begin
      used_addr = cur_nxt[PPN_W-1:0];
    end else begin
      used_addr = ncp_q[PPN_W-1:0];
    end
  end
  assign used_we    = cmd_i.clr_step || cmd_i.take;
  assign used_wdata = cmd_i.take;

  assign entry   = (cmd_q == CMD_DIRTY) ? {1'b1, v2p_rdata[PPN_W-1:0]} : v2p_rdata;
  assign page    = entry[PPN_W-1:0];
  assign mapped  = (page != '0);
  assign pa_full = {page, {PAGE_SHIFT{1'b0}}};

  assign v2p_addr = cmd_i.clr_step ? clr_q[VPN_W-1:0] : vpage_q;
  assign v2p_we   = cmd_i.clr_step || cmd_i.take || (cmd_i.lk_finish && cmd_q == CMD_DIRTY);
  always_comb begin
    if (cmd_i.clr_step) begin
      v2p_wdata = '0;
    end else if (cmd_i.take) begin
      v2p_wdata = {1'b0, ncp_q[PPN_W-1:0]};
    end else begin
      v2p_wdata = entry;
    end
  end

  vpm_ram #(.Width(1), .Depth(PHYS_PAGES)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .addr_i  (used_addr),
    .wdata_i (used_wdata),
    .rdata_o (used_rdata)
  );

  vpm_ram #(.Width(ENTRY_W), .Depth(VIRT_PAGES)) u_v2p_ram (
    .clk_i   (clk_i),
    .we_i    (v2p_we),
    .addr_i  (v2p_addr),
    .wdata_i (v2p_wdata),
    .rdata_o (v2p_rdata)
  );

  always_comb begin
    ncp_d = ncp_q;
    if (cmd_i.prep && (ncp_q < CUR_W'(base_q))) begin
      ncp_d = CUR_W'(base_q);
    end else if (cmd_i.probe) begin
      ncp_d = cur_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      count_q     <= COUNT_W'(PHYS_PAGES);
      clr_q       <= '0;
      ncp_q       <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_BASE:  base_q  <= cfg_data_i[BASE_W-1:0];
          REG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default:   base_q  <= base_q;
        endcase
      end
      if (cmd_i.clr_step) clr_q <= clr_q + CLR_W'(1);
      ncp_q <= ncp_d;
      if (cmd_i.take) alloc_q <= alloc_q + END_W'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      vpage_q <= in_addr_i[PAGE_SHIFT +: VPN_W];
      bytes_q <= in_bytes_i;
    end
    if (cmd_i.prep) begin
      end_q   <= end_c;
      avail_q <= avail_c;
      pages_q <= pages_c;
    end
    if (cmd_i.start_alloc) begin
      rem_q <= pages_q;
      n_q   <= '0;
    end
    if (cmd_i.probe) n_q <= n_q + END_W'(1);
    if (cmd_i.take) begin
      rem_q   <= rem_q - PAGES_W'(1);
      vpage_q <= vpage_q + VPN_W'(1);
      n_q     <= '0;
    end
    if (cmd_i.res_set) begin
      res_ok_q     <= cmd_i.res_val;
      res_pa_q     <= '0;
      res_mapped_q <= 1'b0;
      res_dirty_q  <= 1'b0;
      res_err_q    <= 1'b0;
    end
    if (cmd_i.lk_finish) begin
      res_ok_q     <= (cmd_q == CMD_LOOKUP) ? mapped : 1'b1;
      res_pa_q     <= mapped ? PA_W'(pa_full) : '0;
      res_mapped_q <= mapped;
      res_dirty_q  <= entry[ENTRY_W-1];
      res_err_q    <= (cmd_q == CMD_LOOKUP) && !mapped;
    end
    if (cmd_i.out_load) begin
      out_ok_q     <= res_ok_q;
      out_pa_q     <= res_pa_q;
      out_mapped_q <= res_mapped_q;
      out_dirty_q  <= res_dirty_q;
      out_err_q    <= res_err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_pa_o     = out_pa_q;
  assign out_mapped_o = out_mapped_q;
  assign out_dirty_o  = out_dirty_q;
  assign out_err_o    = out_err_q;

endmodule

// File: hdl/virtual_page_map_allocator_core.sv
// Virtual page map allocator: top level joining sequencer and datapath.
// Depends on vpm_pkg, vpm_ctrl, vpm_datapath and vpm_ram.
//
// Usage:
//   Requests enter on the s_ group: tuser carries the command (allocate,
//   look up, mark dirty), tdata the virtual address and the allocation size.
//   One result per request leaves on the m_ group through an output register.
//   The cfg channel writes the store base page (index 0) and page count (index 1);
//   it is always ready; the user writes it only while the block idles (not enforced).
// Timing:
//   After reset both page tables are cleared one entry a cycle, with s_tready_o
//   low. Lookup and mark dirty pass through S_LK_READ, S_LK_DATA and S_RESP to
//   a valid result. Allocation passes through S_PREP and S_CHECK, then the
//   free-page search visits S_PROBE and S_TEST for every physical page probed
//   and S_PROBE once more when the search gives up: the single port of the
//   usage RAM with its registered read needs a separate test state. One request
//   is in work at a time; the next is accepted the cycle after the result loads.
// Stall:
//   A result held in the output register does not block acceptance; the
//   next result waits in the sequencer until the register drains.
module virtual_page_map_allocator_core import vpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [63:0]           s_tdata_i,  // virtual_address[31:0], alloc_bytes[57:32], zero
  input  logic [1:0]            s_tuser_i,  // cmd[1:0]
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [31:0]           m_tdata_o   // ok[0], physical_address[24:1], mapped[25],
                                            // dirty[26], unmapped_error[27], zero
);

  vpm_cmd_t        cmd;
  vpm_status_t     status;
  logic            out_ok, out_mapped, out_dirty, out_err;
  logic [PA_W-1:0] out_pa;

  vpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_cmd_i   (s_tuser_i),
    .in_ready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vpm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .in_cmd_i     (s_tuser_i),
    .in_addr_i    (s_tdata_i[ADDR_W-1:0]),
    .in_bytes_i   (s_tdata_i[ADDR_W +: BYTES_W]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .out_ok_o     (out_ok),
    .out_pa_o     (out_pa),
    .out_mapped_o (out_mapped),
    .out_dirty_o  (out_dirty),
    .out_err_o    (out_err)
  );

  assign m_tdata_o = {4'b0000, out_err, out_dirty, out_mapped, out_pa, out_ok};

endmodule
